// ===== src/gse_pkg.sv =====
// ----------------------------------------------------------------------------
// gse_pkg
// shared types, sizes and constants of the gaussian/sobel edge detector
// ----------------------------------------------------------------------------
package gse_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 5;

  localparam int DIM_W  = 11;
  localparam int THR_W  = 10;
  localparam int PIX_W  = 10;
  localparam int BLUR_W = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 3 * MAX_WIDTH + 3);

  localparam int SUM_W       = 18;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int GAUSS_SHIFT = 24;
  localparam logic [RECIP_W-1:0] GAUSS_RECIP = 18'd145889;

  localparam int GRAD_W = 15;
  localparam int ABS_W  = 14;
  localparam int SQ_W   = 2 * (ABS_W + 1);

  localparam logic [PIX_W-1:0] FULL_SCALE = 10'd765;

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int OUT_DEPTH   = 16;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

  localparam logic [3:0] GAUSS_W [5][5] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_LOW_THRESHOLD  = 2'd2,
    REG_HIGH_THRESHOLD = 2'd3
  } reg_index_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_t;

  typedef struct packed {
    logic [EW_W-1:0]  width;
    logic [EH_W-1:0]  height;
    logic [THR_W-1:0] low_threshold;
    logic [THR_W-1:0] high_threshold;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] in_col;
    logic [COL_W-1:0] bx;
    logic [ROW_W-1:0] by;
    logic [COL_W-1:0] ox;
    logic [ROW_W-1:0] oy;
    logic             emit;
    logic             last;
  } step_t;

  typedef struct packed {
    logic [BLUR_W-1:0] value;
    logic [COL_W-1:0]  bx;
    logic [COL_W-1:0]  ox;
    logic [ROW_W-1:0]  oy;
    logic              emit;
    logic              last;
  } blur_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_end;
  } result_t;

endpackage

// ===== src/gse_ram.sv =====
// ----------------------------------------------------------------------------
// gse_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gse_front.sv =====
// ----------------------------------------------------------------------------
// gse_front
// accepts items, tracks frame positions, steps pixels and post-input drains
// ----------------------------------------------------------------------------
module gse_front import gse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             restart,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             push,
  output step_t            push_entry,
  input  logic             full
);

  logic [POS_W-1:0] step_count;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] emit_from;
  logic [POS_W-1:0] blur_from;
  logic [POS_W-1:0] last_step;
  logic [COL_W-1:0] in_col;
  logic [COL_W-1:0] bx;
  logic [ROW_W-1:0] by;
  logic [COL_W-1:0] ox;
  logic [ROW_W-1:0] oy;
  logic             input_done;
  logic             emit;
  logic             blur_run;
  logic             at_last;
  logic             col_wrap;
  logic             bx_wrap;
  logic             ox_wrap;

  always_ff @(posedge clk) begin
    total     <= POS_W'(32'(cfg.width) * 32'(cfg.height));
    emit_from <= POS_W'(3 * 32'(cfg.width) + 3);
    blur_from <= POS_W'(2 * 32'(cfg.width) + 2);
    last_step <= POS_W'(32'(cfg.width) * 32'(cfg.height) + 3 * 32'(cfg.width) + 2);
  end

  always_comb begin
    in_ready   = !full;
    input_done = step_count >= total;
    push       = in_valid && in_ready && (input_done || req_type == REQ_PIXEL);
    emit       = step_count >= emit_from;
    blur_run   = step_count >= blur_from;
    at_last    = step_count == last_step;
    col_wrap   = 32'(in_col) == 32'(cfg.width) - 1;
    bx_wrap    = 32'(bx) == 32'(cfg.width) - 1;
    ox_wrap    = 32'(ox) == 32'(cfg.width) - 1;
    push_entry = '{
      pixel:  pixel_in,
      in_col: in_col,
      bx:     bx,
      by:     by,
      ox:     ox,
      oy:     oy,
      emit:   emit,
      last:   emit && at_last
    };
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      step_count <= '0;
      in_col     <= '0;
      bx         <= '0;
      by         <= '0;
      ox         <= '0;
      oy         <= '0;
    end else if (push) begin
      if (at_last) begin
        step_count <= '0;
        in_col     <= '0;
        bx         <= '0;
        by         <= '0;
        ox         <= '0;
        oy         <= '0;
      end else begin
        step_count <= step_count + 1'b1;
        in_col     <= col_wrap ? '0 : in_col + 1'b1;
        if (blur_run) begin
          bx <= bx_wrap ? '0 : bx + 1'b1;
          if (bx_wrap) begin
            by <= by + 1'b1;
          end
        end
        if (emit) begin
          ox <= ox_wrap ? '0 : ox + 1'b1;
          if (ox_wrap) begin
            oy <= oy + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== src/gse_step_queue.sv =====
// ----------------------------------------------------------------------------
// gse_step_queue
// short queue of steps between the front and the processing pipeline
// ----------------------------------------------------------------------------
module gse_step_queue import gse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_entry,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output step_t head
);

  step_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  always_comb begin
    full       = 32'(count) == Q_DEPTH;
    head_valid = count != '0;
    head       = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

endmodule

// ===== src/gse_blur.sv =====
// ----------------------------------------------------------------------------
// gse_blur
// input line buffers, 5x5 window and gaussian smoothing pipeline
// ----------------------------------------------------------------------------
module gse_blur import gse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  step_t in_step,
  output logic  out_valid,
  output blur_t out_blur
);

  logic [PIX_W-1:0]  line_rd [4];
  logic [PIX_W-1:0]  line_wr [4];
  logic [PIX_W-1:0]  col_new [5];
  logic [PIX_W-1:0]  win [5][5];
  logic [SUM_W-1:0]  row_sum [5];
  logic [SUM_W-1:0]  row_sum_q [5];
  logic              border;

  logic              v1, v2, v3, v4, v5;
  step_t             s1, s2, s3, s4, s5;
  logic [PIX_W-1:0]  raw3, raw4, raw5;
  logic              border3, border4, border5;
  logic [SUM_W-1:0]  sum4;
  logic [PROD_W-1:0] prod5;

  always_comb begin
    line_wr[0] = s1.pixel;
    line_wr[1] = line_rd[0];
    line_wr[2] = line_rd[1];
    line_wr[3] = line_rd[2];
    col_new[4] = s1.pixel;
    col_new[3] = line_rd[0];
    col_new[2] = line_rd[1];
    col_new[1] = line_rd[2];
    col_new[0] = line_rd[3];
  end

  for (genvar j = 0; j < 4; j++) begin : g_line
    gse_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   (v1),
      .waddr(s1.in_col),
      .wdata(line_wr[j]),
      .raddr(in_step.in_col),
      .rdata(line_rd[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (v1) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][4] <= col_new[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 5; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < 5; c++) begin
        row_sum[r] = row_sum[r] + SUM_W'(win[r][c]) * SUM_W'(GAUSS_W[r][c]);
      end
    end
    border = (32'(s2.bx) < 2) || (32'(s2.bx) + 3 > 32'(cfg.width))
          || (32'(s2.by) < 2) || (32'(s2.by) + 3 > 32'(cfg.height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    s1        <= in_step;
    s2        <= s1;
    s3        <= s2;
    row_sum_q <= row_sum;
    raw3      <= win[2][2];
    border3   <= border;
    s4        <= s3;
    sum4      <= row_sum_q[0] + row_sum_q[1] + row_sum_q[2] + row_sum_q[3] + row_sum_q[4];
    raw4      <= raw3;
    border4   <= border3;
    s5        <= s4;
    prod5     <= PROD_W'(sum4) * PROD_W'(GAUSS_RECIP);
    raw5      <= raw4;
    border5   <= border4;
    out_blur  <= '{
      value: border5 ? BLUR_W'(raw5) : prod5[GAUSS_SHIFT +: BLUR_W],
      bx:    s5.bx,
      ox:    s5.ox,
      oy:    s5.oy,
      emit:  s5.emit,
      last:  s5.last
    };
  end

endmodule

// ===== src/gse_edge.sv =====
// ----------------------------------------------------------------------------
// gse_edge
// blurred line buffers, 3x3 window, sobel gradient and edge decision
// ----------------------------------------------------------------------------
module gse_edge import gse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  blur_t   in_blur,
  output logic    out_valid,
  output result_t out_result
);

  logic [BLUR_W-1:0] line_rd [2];
  logic [BLUR_W-1:0] line_wr [2];
  logic [BLUR_W-1:0] col_new [3];
  logic [BLUR_W-1:0] win [3][3];

  logic              v1, v2, v3, v4;
  blur_t             t1, t2, t3, t4;

  logic signed [GRAD_W-1:0] gx_c, gy_c;
  logic                     border_c;
  logic signed [GRAD_W-1:0] gx3, gy3;
  logic                     border3, border4;
  logic [BLUR_W-1:0]        nb3 [3][3];
  logic [BLUR_W-1:0]        nb4 [3][3];

  logic [ABS_W-1:0]  abs_x, abs_y;
  logic [ABS_W:0]    sum_xy;
  logic [SQ_W-1:0]   sq_sum4, a2x2_4, diff_sq4;
  logic [PIX_W-1:0]  mag4;
  logic              gx_zero4, gy_zero4, same4, y_le_x4;

  logic              below22, below67, strong_nb, edge_flag;
  dir_t              dir;
  logic [BLUR_W-1:0] left, right;

  always_comb begin
    line_wr[0] = t1.value;
    line_wr[1] = line_rd[0];
    col_new[2] = t1.value;
    col_new[1] = line_rd[0];
    col_new[0] = line_rd[1];
  end

  for (genvar j = 0; j < 2; j++) begin : g_line
    gse_ram #(
      .WIDTH(BLUR_W),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   (v1),
      .waddr(t1.bx),
      .wdata(line_wr[j]),
      .raddr(in_blur.bx),
      .rdata(line_rd[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (v1) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
        win[r][2] <= col_new[r];
      end
    end
  end

  // gradient on the window centered one row and one pixel back
  always_comb begin
    gx_c = signed'(GRAD_W'(win[0][2]) + (GRAD_W'(win[1][2]) << 1) + GRAD_W'(win[2][2]))
         - signed'(GRAD_W'(win[0][0]) + (GRAD_W'(win[1][0]) << 1) + GRAD_W'(win[2][0]));
    gy_c = signed'(GRAD_W'(win[0][0]) + (GRAD_W'(win[0][1]) << 1) + GRAD_W'(win[0][2]))
         - signed'(GRAD_W'(win[2][0]) + (GRAD_W'(win[2][1]) << 1) + GRAD_W'(win[2][2]));
    border_c = (t2.ox == '0) || (32'(t2.ox) + 2 > 32'(cfg.width))
            || (t2.oy == '0) || (32'(t2.oy) + 2 > 32'(cfg.height));
    abs_x  = ABS_W'(gx3 < 0 ? -gx3 : gx3);
    abs_y  = ABS_W'(gy3 < 0 ? -gy3 : gy3);
    sum_xy = (ABS_W+1)'(abs_x) + (ABS_W+1)'(abs_y);
  end

  // direction bins, suppression and double threshold
  always_comb begin
    below22 = sq_sum4 < a2x2_4;
    below67 = y_le_x4 || (diff_sq4 < a2x2_4);
    if (gx_zero4) begin
      dir = gy_zero4 ? DIR_0 : DIR_90;
    end else if (same4) begin
      dir = below22 ? DIR_0 : (below67 ? DIR_45 : DIR_90);
    end else begin
      dir = !below67 ? DIR_90 : (!below22 ? DIR_135 : DIR_0);
    end
    case (dir)
      DIR_0: begin
        left  = nb4[1][0];
        right = nb4[1][2];
      end
      DIR_45: begin
        left  = nb4[2][0];
        right = nb4[0][2];
      end
      DIR_90: begin
        left  = nb4[0][1];
        right = nb4[2][1];
      end
      DIR_135: begin
        left  = nb4[0][0];
        right = nb4[2][2];
      end
      default: begin
        left  = nb4[1][0];
        right = nb4[1][2];
      end
    endcase
    strong_nb = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && nb4[r][c] > BLUR_W'(cfg.high_threshold)) begin
          strong_nb = 1'b1;
        end
      end
    end
    if (BLUR_W'(mag4) < left || BLUR_W'(mag4) < right) begin
      edge_flag = 1'b0;
    end else if (mag4 >= cfg.high_threshold) begin
      edge_flag = 1'b1;
    end else if (mag4 < cfg.low_threshold) begin
      edge_flag = 1'b0;
    end else begin
      edge_flag = strong_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4 && t4.emit;
    end
  end

  always_ff @(posedge clk) begin
    t1       <= in_blur;
    t2       <= t1;
    t3       <= t2;
    gx3      <= gx_c;
    gy3      <= gy_c;
    border3  <= border_c;
    nb3      <= win;
    t4       <= t3;
    border4  <= border3;
    nb4      <= nb3;
    sq_sum4  <= SQ_W'(sum_xy) * SQ_W'(sum_xy);
    a2x2_4   <= (SQ_W'(abs_x) * SQ_W'(abs_x)) << 1;
    diff_sq4 <= (abs_y > abs_x) ? SQ_W'(abs_y - abs_x) * SQ_W'(abs_y - abs_x) : '0;
    mag4     <= (sum_xy > (ABS_W+1)'(FULL_SCALE)) ? FULL_SCALE : PIX_W'(sum_xy);
    gx_zero4 <= gx3 == '0;
    gy_zero4 <= gy3 == '0;
    same4    <= (gx3 > 0) == (gy3 > 0);
    y_le_x4  <= abs_y <= abs_x;
    out_result <= '{
      edge_value: (border4 || !edge_flag) ? FULL_SCALE : '0,
      frame_end:  t4.last
    };
  end

endmodule

// ===== src/gse_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gse_out_fifo
// result queue with slot reservation so the pipeline never has to stall
// ----------------------------------------------------------------------------
module gse_out_fifo import gse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    reserve,
  output logic    space_ok,
  input  logic    wr,
  input  result_t wr_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t              slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_PTR_W:0]   count;
  logic [OUT_PTR_W:0]   reserved;
  logic                 pop;

  always_comb begin
    out_valid = count != '0;
    out_data  = slots[rd_ptr];
    pop       = out_valid && out_ready;
    space_ok  = 32'(reserved) < OUT_DEPTH;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      reserved <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count    <= count + (OUT_PTR_W+1)'(wr) - (OUT_PTR_W+1)'(pop);
      reserved <= reserved + (OUT_PTR_W+1)'(reserve) - (OUT_PTR_W+1)'(pop);
    end
  end

endmodule

// ===== src/gauss_sobel_edge_detector.sv =====
// ----------------------------------------------------------------------------
// gauss_sobel_edge_detector
// streaming 5x5 gaussian, sobel and suppression edge map with apb registers
// ----------------------------------------------------------------------------
// release: a result is released by the input transfer 3 rows plus 3 pixels
//   after its pixel, then passes the step queue, pipelines and output fifo
// throughput: one item per clock, one step per cycle, while no queue is full
// reset: synchronous; positions cleared, 640x480, thresholds 0 and 765;
//   line buffers are not cleared
module gauss_sobel_edge_detector import gse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] edge_value,
  output logic             frame_end
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [THR_W-1:0] low_threshold;
  logic [THR_W-1:0] high_threshold;
  reg_index_t       reg_index;
  logic             cfg_write;
  logic             restart;
  cfg_t             cfg;

  logic    push;
  step_t   push_entry;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  step_t   q_head;
  logic    space_ok;
  logic    blur_valid;
  blur_t   blur_out;
  logic    res_valid;
  result_t res;
  result_t out_data;

  always_comb begin
    pready    = 1'b1;
    reg_index = reg_index_t'(paddr[3:2]);
    cfg_write = psel && penable && pwrite && pready;
    restart   = cfg_write && (reg_index == REG_IMAGE_WIDTH || reg_index == REG_IMAGE_HEIGHT);
    case (reg_index)
      REG_IMAGE_WIDTH:    prdata = 32'(image_width);
      REG_IMAGE_HEIGHT:   prdata = 32'(image_height);
      REG_LOW_THRESHOLD:  prdata = 32'(low_threshold);
      REG_HIGH_THRESHOLD: prdata = 32'(high_threshold);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(640);
      image_height   <= DIM_W'(480);
      low_threshold  <= '0;
      high_threshold <= THR_W'(765);
    end else if (cfg_write) begin
      case (reg_index)
        REG_IMAGE_WIDTH:    image_width    <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= pwdata[DIM_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= pwdata[THR_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry clamped to the supported range
  always_comb begin
    if (32'(image_width) < MIN_DIM) begin
      cfg.width = EW_W'(MIN_DIM);
    end else if (32'(image_width) > MAX_WIDTH) begin
      cfg.width = EW_W'(MAX_WIDTH);
    end else begin
      cfg.width = EW_W'(image_width);
    end
    if (32'(image_height) < MIN_DIM) begin
      cfg.height = EH_W'(MIN_DIM);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      cfg.height = EH_W'(MAX_HEIGHT);
    end else begin
      cfg.height = EH_W'(image_height);
    end
    cfg.low_threshold  = low_threshold;
    cfg.high_threshold = high_threshold;
  end

  gse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .pixel_in  (pixel_in),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full)
  );

  gse_step_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  assign q_pop = q_valid && (!q_head.emit || space_ok);

  gse_blur u_blur (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (q_pop),
    .in_step  (q_head),
    .out_valid(blur_valid),
    .out_blur (blur_out)
  );

  gse_edge u_edge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (blur_valid),
    .in_blur   (blur_out),
    .out_valid (res_valid),
    .out_result(res)
  );

  gse_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .reserve  (q_pop && q_head.emit),
    .space_ok (space_ok),
    .wr       (res_valid),
    .wr_data  (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign edge_value = out_data.edge_value;
  assign frame_end  = out_data.frame_end;

endmodule

// ===== src/gse_checker.sv =====
// ----------------------------------------------------------------------------
// gse_checker
// port-level checks of the edge detector, bound to the top level
// ----------------------------------------------------------------------------
module gse_checker import gse_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] edge_value,
  input logic             frame_end
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_value) && $stable(frame_end))
    else $error("stalled transfer changed");

  a_binary_map: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_value == '0 || edge_value == FULL_SCALE))
    else $error("edge value not binary");

  a_frame_end_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
    else $error("frame end on consecutive results");

endmodule

bind gauss_sobel_edge_detector gse_checker u_gse_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams raster frames through the gaussian/sobel edge detector. The
// expected edge map comes from a software copy of the block's arithmetic.
// Frames of many geometries and thresholds are sent, under random idling on
// both sides. One long output stall fills the pipeline so that it stalls its
// input. Every output transfer is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import gse_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct {
    logic [PIX_W-1:0] edge_value;
    logic             frame_end;
  } edge_result_t;

  typedef enum int {
    STYLE_NOISE,
    STYLE_STEP,
    STYLE_DIM,
    STYLE_EXTREME
  } img_style_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             req_type = REQ_PIXEL;
  logic [PIX_W-1:0] pixel_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] edge_value;
  logic             frame_end;

  gauss_sobel_edge_detector dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [DIM_W-1:0] cfg_width = 11'd640;
  logic [DIM_W-1:0] cfg_height = 11'd480;
  logic [THR_W-1:0] cfg_low = '0;
  logic [THR_W-1:0] cfg_high = 10'd765;
  logic [PIX_W-1:0] row_ring [8*MAX_WIDTH];
  int unsigned      in_pos, out_pos, in_col, in_row, out_col, out_row;

  edge_result_t     edge_queue [$];
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_cnt = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  function automatic int unsigned used_width();
    if (cfg_width < MIN_DIM) return MIN_DIM;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned used_height();
    if (cfg_height < MIN_DIM) return MIN_DIM;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(cfg_height);
  endfunction

  function automatic void clear_positions();
    in_pos = 0; out_pos = 0; in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic int unsigned ring_pixel(int unsigned x, int unsigned y);
    if (x >= MAX_WIDTH) return 0;
    return 32'(row_ring[(y % 8) * MAX_WIDTH + x]);
  endfunction

  function automatic int unsigned blurred(int unsigned x, int unsigned y,
                                          int unsigned w, int unsigned h);
    int unsigned sum;
    sum = 0;
    if (x < 2 || x + 3 > w || y < 2 || y + 3 > h) return ring_pixel(x, y);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        sum += ring_pixel(x + j - 2, y + i - 2) * GAUSS_W[i][j];
    return sum / 115;
  endfunction

  function automatic logic [PIX_W-1:0] edge_pixel(int unsigned x, int unsigned y,
                                                  int unsigned w, int unsigned h);
    int      b [3][3];
    int      gx, gy, mag, lft, rgt;
    longint  a, c;
    bit      below22, below67, same, is_edge;
    dir_t    dir;
    if (x < 1 || x + 2 > w || y < 1 || y + 2 > h) return FULL_SCALE;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        b[i][j] = blurred(x + j - 1, y + i - 1, w, h);
    gx = (b[0][2] + 2 * b[1][2] + b[2][2]) - (b[0][0] + 2 * b[1][0] + b[2][0]);
    gy = (b[0][0] + 2 * b[0][1] + b[0][2]) - (b[2][0] + 2 * b[2][1] + b[2][2]);
    a = (gx < 0) ? -gx : gx;
    c = (gy < 0) ? -gy : gy;
    mag = (a + c > 765) ? 765 : int'(a + c);
    if (gx == 0) begin
      dir = (gy == 0) ? DIR_0 : DIR_90;
    end else begin
      below22 = (a + c) * (a + c) < 2 * a * a;
      below67 = (c <= a) || ((c - a) * (c - a) < 2 * a * a);
      same = (gx > 0) == (gy > 0);
      if (same) dir = below22 ? DIR_0 : (below67 ? DIR_45 : DIR_90);
      else dir = !below67 ? DIR_90 : (!below22 ? DIR_135 : DIR_0);
    end
    case (dir)
      DIR_0:   begin lft = b[1][0]; rgt = b[1][2]; end
      DIR_45:  begin lft = b[2][0]; rgt = b[0][2]; end
      DIR_90:  begin lft = b[0][1]; rgt = b[2][1]; end
      default: begin lft = b[0][0]; rgt = b[2][2]; end
    endcase
    if (mag < lft || mag < rgt) is_edge = 0;
    else if (mag >= cfg_high) is_edge = 1;
    else if (mag < cfg_low) is_edge = 0;
    else begin
      is_edge = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (!(i == 1 && j == 1) && b[i][j] > cfg_high) is_edge = 1;
    end
    return is_edge ? '0 : FULL_SCALE;
  endfunction

  function automatic void predict_edges(logic req, logic [PIX_W-1:0] p);
    int unsigned  w, h, total;
    bit           release_out;
    edge_result_t r;
    w = used_width();
    h = used_height();
    total = w * h;
    if (req == REQ_PIXEL && in_pos < total) begin
      row_ring[(in_row % 8) * MAX_WIDTH + in_col] = p;
      in_pos++;
      if (++in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      release_out = in_pos == total || in_pos >= out_pos + 3 * w + 4;
    end else begin
      release_out = in_pos == total;
    end
    if (!release_out || out_pos >= total) return;
    r.edge_value = edge_pixel(out_col, out_row, w, h);
    r.frame_end = out_pos == total - 1;
    edge_queue.push_back(r);
    out_pos++;
    if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_pos >= total) clear_positions();
  endfunction

  // receiver with random stalls and long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // result checker
  always @(posedge clk) begin
    edge_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (edge_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: edge_value=%0d frame_end=%0b", edge_value, frame_end);
      end else begin
        exp_r = edge_queue.pop_front();
        if (edge_value !== exp_r.edge_value || frame_end !== exp_r.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected edge_value=%0d frame_end=%0b, got %0d %0b",
                     exp_r.edge_value, exp_r.frame_end, edge_value, frame_end);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(reg_index_t idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    begin cfg_width = value[DIM_W-1:0]; clear_positions(); end
      REG_IMAGE_HEIGHT:   begin cfg_height = value[DIM_W-1:0]; clear_positions(); end
      REG_LOW_THRESHOLD:  cfg_low = value[THR_W-1:0];
      REG_HIGH_THRESHOLD: cfg_high = value[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(logic req, logic [PIX_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      req_type <= 1'($urandom_range(1));
      pixel_in <= PIX_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_edges(req, p);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (edge_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(img_style_t style, int x, int y);
    case (style)
      STYLE_STEP:    return (x + y > 6) ? 10'($urandom_range(60, 250)) : 10'($urandom_range(20));
      STYLE_DIM:     return PIX_W'($urandom_range(120));
      STYLE_EXTREME: return ($urandom_range(1)) ? 10'd1023 : 10'd0;
      default:       return ($urandom_range(7) == 0) ? 10'($urandom_range(766, 1023))
                                                     : 10'($urandom_range(765));
    endcase
  endfunction

  task automatic frame_pass(img_style_t style, int noise_pct, int late_pixels);
    int unsigned w, h;
    w = used_width();
    h = used_height();
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(99) < noise_pct) send_item(REQ_DRAIN, PIX_W'($urandom));
        send_item(REQ_PIXEL, pick_pixel(style, x, y));
      end
    for (int i = 0; i < late_pixels && in_pos != 0; i++)
      send_item(REQ_PIXEL, PIX_W'($urandom));
    while (in_pos != 0 || out_pos != 0) send_item(REQ_DRAIN, PIX_W'($urandom));
    send_item(REQ_DRAIN, PIX_W'($urandom));
    wait_idle();
  endtask

  task automatic test_directed();
    cfg_write(REG_IMAGE_WIDTH, 5);
    cfg_write(REG_IMAGE_HEIGHT, 5);
    send_item(REQ_DRAIN, 10'd0);
    for (int i = 0; i < 5; i++) send_item(REQ_PIXEL, (i % 2) ? 10'd765 : 10'd1023);
    send_item(REQ_DRAIN, 10'h3FF);
    for (int i = 0; i < 20; i++) send_item(REQ_PIXEL, (i < 10) ? 10'd0 : 10'd765);
    for (int i = 0; i < 4; i++) send_item(REQ_PIXEL, 10'h2AA);
    while (in_pos != 0) send_item(REQ_DRAIN, 10'h155);
    send_item(REQ_DRAIN, 10'd0);
    wait_idle();
    // partial frame, then geometry write abandons it; sizes below minimum clamp
    for (int i = 0; i < 7; i++) send_item(REQ_PIXEL, PIX_W'($urandom));
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 0);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    cfg_write(REG_LOW_THRESHOLD, 1023);
    cfg_write(REG_HIGH_THRESHOLD, 1023);
    frame_pass(STYLE_EXTREME, 0, 0);
    cfg_write(REG_LOW_THRESHOLD, 0);
    cfg_write(REG_HIGH_THRESHOLD, 0);
    frame_pass(STYLE_STEP, 0, 0);
  endtask

  task automatic test_random_frames(int frames);
    for (int f = 0; f < frames; f++) begin
      cfg_write(REG_IMAGE_WIDTH, $urandom_range(5, 7));
      cfg_write(REG_IMAGE_HEIGHT, $urandom_range(5, 6));
      case ($urandom_range(3))
        0: begin
          cfg_write(REG_LOW_THRESHOLD, 0);
          cfg_write(REG_HIGH_THRESHOLD, 765);
        end
        1: begin
          cfg_write(REG_LOW_THRESHOLD, $urandom_range(20, 150));
          cfg_write(REG_HIGH_THRESHOLD, $urandom_range(150, 400));
        end
        2: cfg_write(REG_HIGH_THRESHOLD, $urandom_range(1023));
        default: cfg_write(REG_LOW_THRESHOLD, $urandom_range(1023));
      endcase
      frame_pass(img_style_t'($urandom_range(3)), 6, $urandom_range(3));
    end
  endtask

  task automatic test_geometry_extremes();
    cfg_write(REG_LOW_THRESHOLD, 40);
    cfg_write(REG_HIGH_THRESHOLD, 200);
    cfg_write(REG_IMAGE_WIDTH, 4);
    cfg_write(REG_IMAGE_HEIGHT, 2);
    frame_pass(STYLE_STEP, 0, 0);
  endtask

  task automatic test_output_backpressure();
    cfg_write(REG_IMAGE_WIDTH, 8);
    cfg_write(REG_IMAGE_HEIGHT, 6);
    hold_cnt = 400;
    frame_pass(STYLE_NOISE, 0, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 84;
    test_directed();
    test_random_frames(1);
    send_idle_pct = 84;
    recv_idle_pct = 17;
    test_random_frames(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(1);
    test_output_backpressure();
    test_geometry_extremes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && edge_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
